// ===== sv/cadf_pkg.sv =====
// Shared types and constants for the chunk-aligned record deframer.
package cadf_pkg;

  // Reset value of the chunk size register.
  localparam logic [31:0] CHUNK_SIZE_RESET = 32'd16777216;

  // Bytes in a record length field; smaller chunk sizes turn chunking off.
  localparam logic [31:0] LENGTH_BYTES = 32'd4;

  // Bytes at the end of a chunk in which no length may start.
  localparam logic [32:0] TAIL_BYTES = 33'd3;

  // Register index codes, taken from paddr[2].
  localparam logic REG_CHUNK_SIZE = 1'b0;

  // Byte lanes of the length accumulator.
  localparam logic [1:0] LANE_0 = 2'd0;
  localparam logic [1:0] LANE_1 = 2'd1;
  localparam logic [1:0] LANE_2 = 2'd2;
  localparam logic [1:0] LANE_3 = 2'd3;

  // One result item as it travels from the parser to the output register.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] record_length;
    logic        last_of_record;
  } result_t;

endpackage

// ===== sv/cadf_parse.sv =====
// Parse state and next-state logic of the record deframer.
module cadf_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            resync,
  input  logic [31:0]     chunk_size,
  output logic            res_valid,
  output cadf_pkg::result_t res
);
  import cadf_pkg::*;

  // Parse state registers.
  logic [31:0] chunk_position;
  logic        reading_length;
  logic [1:0]  length_byte_count;
  logic [31:0] length_accumulator;
  logic [31:0] payload_remaining;
  logic [31:0] current_length;

  logic [31:0] chunk_position_next;
  logic        reading_length_next;
  logic [1:0]  length_byte_count_next;
  logic [31:0] length_accumulator_next;
  logic [31:0] payload_remaining_next;
  logic [31:0] current_length_next;

  // State as seen by this item, after an optional resync.
  logic [31:0] start_pos;
  logic        start_reading;
  logic [1:0]  start_cnt;
  logic [31:0] start_acc;
  logic [31:0] start_rem;
  logic [31:0] start_cur;

  logic        chunking_on;
  logic        in_tail;
  logic [32:0] pos_inc;

  // A resync clears the parse state and the chunk position before the byte is used.
  always_comb begin
    if (resync) begin
      start_pos     = '0;
      start_reading = 1'b1;
      start_cnt     = '0;
      start_acc     = '0;
      start_rem     = '0;
      start_cur     = '0;
    end else begin
      start_pos     = chunk_position;
      start_reading = reading_length;
      start_cnt     = length_byte_count;
      start_acc     = length_accumulator;
      start_rem     = payload_remaining;
      start_cur     = current_length;
    end
  end

  // Chunk tail test and position advance.
  assign chunking_on = (chunk_size >= LENGTH_BYTES);
  assign in_tail     = chunking_on &&
                       (({1'b0, start_pos} + TAIL_BYTES) >= {1'b0, chunk_size});
  assign pos_inc     = {1'b0, start_pos} + 33'd1;

  always_comb begin
    if (!chunking_on) begin
      chunk_position_next = '0;
    end else if (pos_inc >= {1'b0, chunk_size}) begin
      chunk_position_next = '0;
    end else begin
      chunk_position_next = pos_inc[31:0];
    end
  end

  // Length collection and payload pass-through.
  always_comb begin
    reading_length_next     = start_reading;
    length_byte_count_next  = start_cnt;
    length_accumulator_next = start_acc;
    payload_remaining_next  = start_rem;
    current_length_next     = start_cur;
    res_valid               = 1'b0;
    res.data_byte           = in_byte;
    res.record_length       = start_cur;
    res.last_of_record      = (start_rem <= 32'd1);

    if (start_reading) begin
      // Only the first byte of a length is checked against the chunk tail.
      if (!((start_cnt == LANE_0) && in_tail)) begin
        case (start_cnt)
          LANE_0:  length_accumulator_next[7:0]   = in_byte;
          LANE_1:  length_accumulator_next[15:8]  = in_byte;
          LANE_2:  length_accumulator_next[23:16] = in_byte;
          LANE_3:  length_accumulator_next[31:24] = in_byte;
          default: length_accumulator_next        = start_acc;
        endcase
        length_byte_count_next = start_cnt + 2'd1;
        if (start_cnt == LANE_3) begin
          // A zero length is padding and leaves the block waiting for a length.
          if (length_accumulator_next != 32'd0) begin
            reading_length_next    = 1'b0;
            current_length_next    = length_accumulator_next;
            payload_remaining_next = length_accumulator_next;
          end
          length_accumulator_next = '0;
        end
      end
    end else begin
      res_valid = 1'b1;
      if (start_rem <= 32'd1) begin
        reading_length_next     = 1'b1;
        length_byte_count_next  = '0;
        length_accumulator_next = '0;
        payload_remaining_next  = '0;
        current_length_next     = '0;
      end else begin
        payload_remaining_next = start_rem - 32'd1;
      end
    end
  end

  // State update on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_position     <= '0;
      reading_length     <= 1'b1;
      length_byte_count  <= '0;
      length_accumulator <= '0;
      payload_remaining  <= '0;
      current_length     <= '0;
    end else if (accept) begin
      chunk_position     <= chunk_position_next;
      reading_length     <= reading_length_next;
      length_byte_count  <= length_byte_count_next;
      length_accumulator <= length_accumulator_next;
      payload_remaining  <= payload_remaining_next;
      current_length     <= current_length_next;
    end
  end

endmodule

// ===== sv/cadf_out_reg.sv =====
// Result register that holds one item until the receiver takes it.
module cadf_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cadf_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              can_load,
  output cadf_pkg::result_t held
);
  import cadf_pkg::*;

  // The register frees up in the same cycle the receiver takes its item.
  assign can_load = !out_valid || out_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload, no reset needed.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

// ===== sv/chunk_aligned_record_deframer_core.sv =====
// Top level of the chunk-aligned record deframer.
//
// Usage: the input channel (in_valid/in_ready) carries one raw log byte per
// item in in_byte, with resync set on a byte that starts a chunk. Each record
// is a 4-byte little-endian length and then its payload; zero lengths are
// padding, and a length may not start in the last 3 bytes of a chunk.
// The output channel (out_valid/out_ready) carries one payload byte per item
// with its record_length and last_of_record on the final byte.
// A payload byte appears on the output in the cycle after it is accepted.
// Throughput: one item per cycle while the receiver does not stall, set by
// the single result register; length and skipped bytes give no output item.
// When the receiver stalls, the held item stays put and in_ready drops until
// out_ready returns; in_ready is high whenever the result register is empty
// or being emptied in the same cycle.
// Reset (rst, synchronous) clears the parse state and chunk position, empties
// the result register and sets chunk_size to 16777216. chunk_size is written
// at byte address 0 of the APB port; the user must write it only while the block
// is idle, which the block does not enforce; below 4 it turns chunk boundary skipping off.
module chunk_aligned_record_deframer_core (
  input  logic        clk,
  input  logic        rst,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        resync,
  // Output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic [31:0] record_length,
  output logic        last_of_record,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cadf_pkg::*;

  logic [31:0] chunk_size;
  logic        accept;
  logic        res_valid;
  logic        can_load;
  result_t     res;
  result_t     held;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size <= CHUNK_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CHUNK_SIZE)) begin
      chunk_size <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_CHUNK_SIZE) ? chunk_size : 32'd0;

  // Handshake.
  assign in_ready = can_load;
  assign accept   = in_valid && in_ready;

  cadf_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (in_byte),
    .resync     (resync),
    .chunk_size (chunk_size),
    .res_valid  (res_valid),
    .res        (res)
  );

  cadf_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .held      (held)
  );

  // Result fields.
  assign data_byte      = held.data_byte;
  assign record_length  = held.record_length;
  assign last_of_record = held.last_of_record;

endmodule

// ===== sv/cadf_checker.sv =====
// Port-level checks for the record deframer, bound to its top level.
module cadf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] record_length,
  input logic        pready
);

  // A held item stays until the receiver takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  // An empty result register always takes a new item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result register not empty after reset");

  // Payload bytes only come from records of nonzero length.
  a_nonzero_length: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> record_length != 32'd0)
    else $error("payload byte with zero record length");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind chunk_aligned_record_deframer_core cadf_checker u_cadf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .record_length (record_length),
  .pready        (pready)
);

// ===== sim/deframer_checker.sv =====
// Checker that predicts the deframer's payload items and compares them with its output.
module deframer_checker
  import cadf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        resync,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  data_byte,
  input  logic [31:0] record_length,
  input  logic        last_of_record,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned failures,
  output int unsigned expected_left
);

  // Shadow of the chunk size register and of the parser state.
  logic [31:0] chunk_bytes;
  logic [31:0] chunk_pos;
  logic        want_length;
  logic [1:0]  len_lane;
  logic [31:0] len_gather;
  logic [31:0] bytes_left;
  logic [31:0] rec_len;

  // Payload items still owed by the block, oldest first.
  result_t payload_q[$];
  result_t due;

  // Drop any partial record and go back to waiting for a length.
  function automatic void clear_record();
    want_length = 1'b1;
    len_lane    = LANE_0;
    len_gather  = '0;
    bytes_left  = '0;
    rec_len     = '0;
  endfunction

  // A length may not start in the last bytes of a chunk, or past its end.
  function automatic logic at_chunk_tail();
    if (chunk_bytes < LENGTH_BYTES) return 1'b0;
    return ({1'b0, chunk_pos} + TAIL_BYTES) >= {1'b0, chunk_bytes};
  endfunction

  // Run one accepted log byte through the parser and queue any payload item.
  task automatic deframe_byte(input logic [7:0] raw, input logic restart);
    result_t     item;
    logic [32:0] next_pos;
    if (restart) begin
      clear_record();
      chunk_pos = '0;
    end
    if (want_length) begin
      // Only the first length byte is held back by the chunk tail.
      if (!(len_lane == LANE_0 && at_chunk_tail())) begin
        len_gather = len_gather | (32'(raw) << (8 * len_lane));
        len_lane   = len_lane + 2'd1;
        if (len_lane == LANE_0) begin
          if (len_gather != '0) begin
            want_length = 1'b0;
            rec_len     = len_gather;
            bytes_left  = len_gather;
          end
          len_gather = '0;
        end
      end
    end else begin
      item.data_byte      = raw;
      item.record_length  = rec_len;
      item.last_of_record = (bytes_left <= 32'd1);
      payload_q.push_back(item);
      if (bytes_left <= 32'd1) clear_record();
      else bytes_left = bytes_left - 32'd1;
    end
    // The position counter wraps at the chunk size and idles when chunking is off.
    if (chunk_bytes < LENGTH_BYTES) begin
      chunk_pos = '0;
    end else begin
      next_pos  = {1'b0, chunk_pos} + 33'd1;
      chunk_pos = (next_pos >= {1'b0, chunk_bytes}) ? '0 : next_pos[31:0];
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      chunk_bytes = CHUNK_SIZE_RESET;
      chunk_pos   = '0;
      clear_record();
      payload_q.delete();
    end else begin
      // Outputs are matched before this edge's input is predicted: the block
      // registers each item before it appears on the output.
      if (out_valid && out_ready) begin
        if (payload_q.size() == 0) begin
          $error("unexpected item: data_byte %0h record_length %0h last_of_record %0b",
                 data_byte, record_length, last_of_record);
          failures++;
        end else begin
          due = payload_q.pop_front();
          if (data_byte !== due.data_byte) begin
            $error("data_byte: expected %0h, got %0h", due.data_byte, data_byte);
            failures++;
          end
          if (record_length !== due.record_length) begin
            $error("record_length: expected %0h, got %0h", due.record_length, record_length);
            failures++;
          end
          if (last_of_record !== due.last_of_record) begin
            $error("last_of_record: expected %0b, got %0b", due.last_of_record,
                   last_of_record);
            failures++;
          end
        end
      end
      if (in_valid && in_ready) deframe_byte(in_byte, resync);
      // Register writes update the shadow; reads of chunk_size must match it.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_CHUNK_SIZE) chunk_bytes = pwdata;
        end else if (paddr[2] == REG_CHUNK_SIZE && prdata !== chunk_bytes) begin
          $error("chunk_size: expected %0h, got %0h", chunk_bytes, prdata);
          failures++;
        end
      end
    end
    expected_left = payload_q.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Testbench top: stimulus, receiver stalls and verdict for the record deframer.
module testbench;
  import cadf_pkg::*;

  localparam int unsigned HALF_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES    = 5;
  localparam int unsigned IDLE_PCT        = 12;
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned PHASE_ITEMS     = 100;
  localparam int unsigned LIMIT_CYCLES    = 400000;

  // Chunks larger than this are never padded out, since filling one would take too long.
  localparam logic [31:0] PAD_CHUNK_MAX   = 32'd256;

  // Byte addresses on the configuration port.
  localparam logic [2:0] ADDR_CHUNK_SIZE = {REG_CHUNK_SIZE, 2'b00};
  localparam logic [2:0] ADDR_UNUSED     = 3'd4;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        resync;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  data_byte;
  logic [31:0] record_length;
  logic        last_of_record;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned failures;
  int unsigned expected_left;

  // Stimulus-side view of the chunk layout, used only to shape the log.
  logic [31:0] gen_chunk;
  logic [31:0] gen_pos;
  bit          force_resync;
  bit          steady;
  bit          hold_request;
  int unsigned sent_items;

  chunk_aligned_record_deframer_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .resync         (resync),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_byte      (data_byte),
    .record_length  (record_length),
    .last_of_record (last_of_record),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  deframer_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .resync         (resync),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_byte      (data_byte),
    .record_length  (record_length),
    .last_of_record (last_of_record),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .failures       (failures),
    .expected_left  (expected_left)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // True when a length would start inside the tail of the current chunk.
  function automatic bit gen_tail();
    if (gen_chunk < LENGTH_BYTES) return 1'b0;
    return ({1'b0, gen_pos} + TAIL_BYTES) >= {1'b0, gen_chunk};
  endfunction

  // Offer one byte, with a random gap first, and wait until it is taken.
  task automatic push_byte(input logic [7:0] raw, input logic restart, input bit counted);
    logic [32:0] next_pos;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= raw;
    resync   <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (restart) gen_pos = '0;
    if (gen_chunk < LENGTH_BYTES) begin
      gen_pos = '0;
    end else begin
      next_pos = {1'b0, gen_pos} + 33'd1;
      gen_pos  = (next_pos >= {1'b0, gen_chunk}) ? '0 : next_pos[31:0];
    end
    if (counted) sent_items++;
  endtask

  // Four-byte little-endian length, with an optional resync on its first byte.
  task automatic push_length(input logic [31:0] len, input logic restart);
    for (int i = 0; i < 4; i++) push_byte(len[8*i +: 8], restart && (i == 0), 1'b1);
  endtask

  // Fill the rest of the chunk the way a writer would: zero lengths, then junk in the tail.
  task automatic pad_chunk();
    if (gen_chunk < LENGTH_BYTES) return;
    while (gen_pos != '0) begin
      if (gen_tail()) push_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      else repeat (4) push_byte(8'h00, 1'b0, 1'b0);
    end
  endtask

  // One record; body below len leaves it cut short.
  task automatic send_record(input logic [31:0] len, input int unsigned body);
    logic [32:0] span;
    bit          restart;
    span    = {1'b0, gen_pos} + 33'(len) + 33'(LENGTH_BYTES);
    restart = force_resync;
    // Records that do not fit mostly start on the next chunk; a few cross over.
    if (!restart && gen_chunk >= LENGTH_BYTES && gen_chunk <= PAD_CHUNK_MAX) begin
      if (gen_tail() || (span > {1'b0, gen_chunk} && $urandom_range(9) != 0)) pad_chunk();
    end
    if (!restart && gen_pos == '0 && $urandom_range(7) == 0) restart = 1'b1;
    force_resync = 1'b0;
    push_length(len, restart);
    for (int unsigned k = 0; k < body; k++) push_byte(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Mostly well-formed records, with some noise, cut records and padding.
  task automatic run_phase(input int unsigned budget);
    int unsigned goal;
    int unsigned pick;
    logic [31:0] len;
    goal = sent_items + budget;
    while (sent_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        repeat ($urandom_range(6, 1)) begin
          push_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        end
        force_resync = 1'b1;
      end else if (pick < 11) begin
        len = $urandom();
        if ($urandom_range(1) != 0) len = $urandom_range(12, 2);
        if (len < 32'd2) len = 32'd2;
        send_record(len, (len > 32'd9) ? $urandom_range(8) : $urandom_range(len - 1));
        force_resync = 1'b1;
      end else if (pick < 16) begin
        send_record('0, 0);
      end else if (pick < 22) begin
        len = $urandom_range(40, 13);
        send_record(len, len);
      end else begin
        len = $urandom_range(12, 1);
        send_record(len, len);
      end
    end
  endtask

  // Stop offering bytes and let every owed item come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reprogram the chunk size while idle and read it back.
  task automatic set_chunk(input logic [31:0] size_bytes);
    drain();
    apb_access(1'b1, ADDR_CHUNK_SIZE, size_bytes);
    apb_access(1'b0, ADDR_CHUNK_SIZE, '0);
    gen_chunk = size_bytes;
  endtask

  // Receiver: random stalls, one long hold-off on request, none while steady.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_byte  <= '0;
    resync   <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    gen_chunk    = CHUNK_SIZE_RESET;
    gen_pos      = '0;
    force_resync = 1'b0;
    steady       = 1'b0;
    hold_request = 1'b0;
    sent_items   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Shortest record, carrying an all-ones byte.
    push_length(32'd1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    // A zero length is padding and yields nothing.
    push_length(32'd0, 1'b0);
    // Longest length, abandoned by a resync on the next length.
    push_length(32'hFFFF_FFFF, 1'b0);
    push_byte(8'h00, 1'b0, 1'b1);
    push_byte(8'hA5, 1'b0, 1'b1);
    push_length(32'd2, 1'b1);
    push_byte(8'h5A, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);

    run_phase(PHASE_ITEMS);
    // Chunking off, both at zero and just below a length.
    set_chunk(32'd0);
    run_phase(PHASE_ITEMS);
    set_chunk(32'd3);
    steady = 1'b1;
    run_phase(PHASE_ITEMS);
    steady = 1'b0;
    // Smallest chunk: only the first byte may start a length.
    set_chunk(32'd4);
    run_phase(PHASE_ITEMS);
    // Receiver holds off while the sender keeps pushing.
    set_chunk(32'd16);
    hold_request = 1'b1;
    run_phase(PHASE_ITEMS);
    // A write to an unused address must leave chunk_size alone.
    drain();
    apb_access(1'b1, ADDR_UNUSED, $urandom());
    apb_access(1'b0, ADDR_CHUNK_SIZE, '0);
    set_chunk(32'd13);
    run_phase(PHASE_ITEMS);
    // Leave the position well past the smaller size that follows.
    set_chunk(32'd64);
    run_phase(PHASE_ITEMS);
    pad_chunk();
    send_record(32'd20, 20);
    set_chunk(32'd8);
    run_phase(PHASE_ITEMS);
    set_chunk(32'hFFFF_FFFF);
    run_phase(PHASE_ITEMS);
    set_chunk(32'd7);
    run_phase(PHASE_ITEMS);

    drain();
    if (failures == 0 && expected_left == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== chunk_aligned_record_deframer_core.f =====
sv/cadf_pkg.sv
sv/cadf_parse.sv
sv/cadf_out_reg.sv
sv/chunk_aligned_record_deframer_core.sv
sv/cadf_checker.sv
sim/deframer_checker.sv
sim/testbench.sv
